/* src/tsp_pkg.sv */
// shared types, constants and helpers for the track stream to pulse widths block
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

	localparam int STORE_BYTES  = 16384;
	localparam int START_OFFSET = 4;
	localparam int ADDR_W       = $clog2(STORE_BYTES);

	localparam logic [ADDR_W-1:0] PTR_START = ADDR_W'(START_OFFSET);
	localparam logic [ADDR_W-1:0] PTR_LAST  = ADDR_W'(STORE_BYTES - 1);
	localparam logic [ADDR_W-1:0] STEP_MAX  = ADDR_W'(STORE_BYTES - 1);

	localparam logic [7:0] FILLER_BYTE   = 8'h55;
	localparam logic [7:0] MARK_UNKNOWN  = 8'hff;
	localparam logic [7:0] END_RESET     = 8'hff;
	localparam logic [7:0] SECTOR_RESET  = 8'h01;

	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_REWIND = 2'd1;
	localparam logic [1:0] FUNC_FETCH  = 2'd2;

	localparam logic CFG_END_MARKER    = 1'b0;
	localparam logic CFG_SECTOR_MARKER = 1'b1;

	localparam logic [1:0] CAP_SIDE   = 2'd0;
	localparam logic [1:0] CAP_TRACK  = 2'd1;
	localparam logic [1:0] CAP_SECTOR = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] address;
		logic [7:0]        data;
	} req_t;

	typedef struct packed {
		logic [3:0] pulse_a;
		logic [3:0] pulse_b;
		logic [3:0] pulse_c;
		logic [3:0] pulse_d;
		logic [7:0] cur_side;
		logic [7:0] cur_track;
		logic [7:0] cur_sector;
		logic       is_filler;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EXAM,
		ST_CAP_RD,
		ST_CAP_WR
	} state_t;

	typedef struct packed {
		logic       wr_en;
		logic       rewind;
		logic       load_steps;
		logic       dec_steps;
		logic       rd_issue;
		logic       advance;
		logic       cap_en;
		logic [1:0] cap_sel;
		logic       set_result;
		logic       filler;
	} cmd_t;

	typedef struct packed {
		logic steps_zero;
		logic is_end;
		logic is_zero;
		logic is_sector;
	} stat_t;

	function automatic logic [3:0] reload_of_code(input logic [1:0] code);
		logic [3:0] r;
		case (code)
			2'd0:    r = 4'd7;
			2'd1:    r = 4'd7;
			2'd2:    r = 4'd11;
			2'd3:    r = 4'd15;
			default: r = 4'd7;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/track_stream_to_pulse_widths.sv */
// top level of the track stream to pulse widths block
//
// Requests enter on start/request and are taken when start is high and busy
// is low. A write request stores request.data at request.address; a rewind
// request sets the read pointer to the stream start and marks side, track and
// sector unknown (255). Neither gives a result.
// A fetch request walks the track store and gives one result, shown on result
// for exactly one cycle with result_strobe high, in the first cycle busy is low.
// Each byte examined takes a read issue, then a compare on the registered read
// data of the store's single read port; a sector marker adds a read and a
// capture for each of its three id bytes. The walk gives up after 16383
// examined bytes with the filler 0x55.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; they need no handshake.
// Reset sets the pointer to the stream start, ids to 255, end marker to 255
// and sector marker to 1; store contents are not cleared.
// The receiver cannot stall: each result is valid for its single strobe cycle.
`timescale 1ns / 1ps
`default_nettype none

module track_stream_to_pulse_widths import tsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire req_t       request,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	output res_t            result,
	output logic            result_strobe
);

	cmd_t  cmd;
	stat_t stat;

	tsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (request.func),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	tsp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.request       (request),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.stat          (stat),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

`default_nettype wire

/* src/tsp_ctrl.sv */
// controller state machine: sequences the store walk for a fetch request
`timescale 1ns / 1ps
`default_nettype none

module tsp_ctrl import tsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] func,
	input  wire stat_t      stat,
	output logic            busy,
	output cmd_t            cmd
);

	state_t     state_q, state_d;
	logic [1:0] cap_cnt_q;

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_cnt_q <= CAP_SIDE;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXAM) begin
				cap_cnt_q <= CAP_SIDE;
			end else if (state_q == ST_CAP_WR) begin
				cap_cnt_q <= cap_cnt_q + 2'd1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && func == FUNC_FETCH) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = stat.steps_zero ? ST_IDLE : ST_EXAM;
			end
			ST_EXAM: begin
				if (stat.is_end) state_d = ST_IDLE;
				else if (stat.is_zero) state_d = ST_CHECK;
				else if (stat.is_sector) state_d = ST_CAP_RD;
				else state_d = ST_IDLE;
			end
			ST_CAP_RD: begin
				state_d = ST_CAP_WR;
			end
			ST_CAP_WR: begin
				state_d = (cap_cnt_q == CAP_SECTOR) ? ST_CHECK : ST_CAP_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.cap_sel = cap_cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (func)
						FUNC_WRITE:  cmd.wr_en = 1'b1;
						FUNC_REWIND: cmd.rewind = 1'b1;
						FUNC_FETCH:  cmd.load_steps = 1'b1;
						default:     cmd = cmd;
					endcase
				end
			end
			ST_CHECK: begin
				if (stat.steps_zero) begin
					cmd.set_result = 1'b1;
					cmd.filler     = 1'b1;
				end else begin
					cmd.dec_steps = 1'b1;
					cmd.rd_issue  = 1'b1;
				end
			end
			ST_EXAM: begin
				if (stat.is_end) begin
					cmd.set_result = 1'b1;
					cmd.filler     = 1'b1;
				end else begin
					cmd.advance = 1'b1;
					if (!stat.is_zero && !stat.is_sector) cmd.set_result = 1'b1;
				end
			end
			ST_CAP_RD: begin
				cmd.rd_issue = 1'b1;
			end
			ST_CAP_WR: begin
				cmd.cap_en  = 1'b1;
				cmd.advance = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/tsp_dp.sv */
// datapath: track store, read pointer, step count, captured ids and result register
`timescale 1ns / 1ps
`default_nettype none

module tsp_dp import tsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire req_t       request,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire cmd_t       cmd,
	output stat_t           stat,
	output res_t            result,
	output logic            result_strobe
);

	logic [7:0]        mem [STORE_BYTES];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] steps_q;
	logic [7:0]        end_marker_q;
	logic [7:0]        sector_marker_q;
	logic [7:0]        side_q;
	logic [7:0]        track_q;
	logic [7:0]        sector_q;
	res_t              res_q;
	logic              strobe_q;
	logic [7:0]        out_byte;

	// track store
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[request.address] <= request.data;
		if (cmd.rd_issue) rdata_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q           <= PTR_START;
			steps_q         <= STEP_MAX;
			end_marker_q    <= END_RESET;
			sector_marker_q <= SECTOR_RESET;
			side_q          <= MARK_UNKNOWN;
			track_q         <= MARK_UNKNOWN;
			sector_q        <= MARK_UNKNOWN;
			strobe_q        <= 1'b0;
		end else begin
			strobe_q <= cmd.set_result;
			if (cfg_we) begin
				if (cfg_index == CFG_END_MARKER) end_marker_q <= cfg_data;
				else sector_marker_q <= cfg_data;
			end
			if (cmd.rewind) begin
				ptr_q    <= PTR_START;
				side_q   <= MARK_UNKNOWN;
				track_q  <= MARK_UNKNOWN;
				sector_q <= MARK_UNKNOWN;
			end else if (cmd.advance) begin
				ptr_q <= (ptr_q == PTR_LAST) ? PTR_START : ptr_q + ADDR_W'(1);
			end
			if (cmd.load_steps) steps_q <= STEP_MAX;
			else if (cmd.dec_steps) steps_q <= steps_q - ADDR_W'(1);
			if (cmd.cap_en) begin
				case (cmd.cap_sel)
					CAP_SIDE:   side_q   <= rdata_q;
					CAP_TRACK:  track_q  <= rdata_q;
					CAP_SECTOR: sector_q <= rdata_q;
					default:    sector_q <= sector_q;
				endcase
			end
		end
	end

	assign stat.steps_zero = (steps_q == '0);
	assign stat.is_end     = (rdata_q == end_marker_q);
	assign stat.is_zero    = (rdata_q == 8'd0);
	assign stat.is_sector  = (rdata_q == sector_marker_q);

	assign out_byte = cmd.filler ? FILLER_BYTE : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.set_result) begin
			res_q.pulse_a    <= reload_of_code(out_byte[7:6]);
			res_q.pulse_b    <= reload_of_code(out_byte[5:4]);
			res_q.pulse_c    <= reload_of_code(out_byte[3:2]);
			res_q.pulse_d    <= reload_of_code(out_byte[1:0]);
			res_q.cur_side   <= side_q;
			res_q.cur_track  <= track_q;
			res_q.cur_sector <= sector_q;
			res_q.is_filler  <= cmd.filler;
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire

/* tb/tb_track_stream_to_pulse_widths.sv */
// testbench for track_stream_to_pulse_widths: predicted fetch results checked against the block
`timescale 1ns / 1ps

module tb_track_stream_to_pulse_widths;
	import tsp_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int IDLE_LIMIT  = 400000;
	localparam int BLOCK_ITEMS = 260;
	localparam int GUARD_AT    = START_OFFSET + 100;
	localparam int GUARD_LEN   = 4;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	req_t       request = '0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_END_MARKER;
	logic [7:0] cfg_data = '0;
	logic       busy;
	res_t       result;
	logic       result_strobe;

	track_stream_to_pulse_widths dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result(result),
		.result_strobe(result_strobe)
	);

	logic [7:0]        track_copy [STORE_BYTES];
	logic [ADDR_W-1:0] walk_ptr;
	logic [7:0]        side_seen, track_seen, sector_seen;
	logic [7:0]        end_code, sector_code;
	res_t              expected_pulses [$];
	res_t              want;
	logic [3:0]        reload_of [4] = '{4'd7, 4'd7, 4'd11, 4'd15};

	int idle_pct = 0;
	int requests_sent = 0;
	int fetches_checked = 0;
	int fillers_predicted = 0;
	int settings_used = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic req_t make_req(input logic [1:0] f, input logic [ADDR_W-1:0] a,
			input logic [7:0] d);
		req_t r;
		r.func = f;
		r.address = a;
		r.data = d;
		return r;
	endfunction

	task automatic step_walk();
		walk_ptr = (walk_ptr == PTR_LAST) ? PTR_START : walk_ptr + 1'b1;
	endtask

	task automatic read_id(output logic [7:0] v);
		v = track_copy[walk_ptr];
		step_walk();
	endtask

	task automatic predict_request(input req_t r);
		int         steps;
		logic [7:0] v;
		logic [7:0] b;
		logic       filler;
		res_t       e;
		case (r.func)
			FUNC_WRITE: begin
				track_copy[r.address] = r.data;
			end
			FUNC_REWIND: begin
				walk_ptr = PTR_START;
				side_seen = MARK_UNKNOWN;
				track_seen = MARK_UNKNOWN;
				sector_seen = MARK_UNKNOWN;
			end
			FUNC_FETCH: begin
				b = FILLER_BYTE;
				filler = 1'b1;
				steps = STORE_BYTES;
				while (1) begin
					steps--;
					if (steps == 0) break;
					v = track_copy[walk_ptr];
					if (v == end_code) break;
					step_walk();
					if (v == 8'h00) continue;
					if (v == sector_code) begin
						read_id(side_seen);
						read_id(track_seen);
						read_id(sector_seen);
					end else begin
						b = v;
						filler = 1'b0;
						break;
					end
				end
				e.pulse_a = reload_of[b[7:6]];
				e.pulse_b = reload_of[b[5:4]];
				e.pulse_c = reload_of[b[3:2]];
				e.pulse_d = reload_of[b[1:0]];
				e.cur_side = side_seen;
				e.cur_track = track_seen;
				e.cur_sector = sector_seen;
				e.is_filler = filler;
				if (filler) fillers_predicted++;
				expected_pulses.push_back(e);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got);
		if (got !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (expected_pulses.size() == 0) begin
				$error("result strobe with no fetch outstanding");
				mismatches++;
			end else begin
				want = expected_pulses.pop_front();
				check_field("pulse_a", 8'(want.pulse_a), 8'(result.pulse_a));
				check_field("pulse_b", 8'(want.pulse_b), 8'(result.pulse_b));
				check_field("pulse_c", 8'(want.pulse_c), 8'(result.pulse_c));
				check_field("pulse_d", 8'(want.pulse_d), 8'(result.pulse_d));
				check_field("cur_side", want.cur_side, result.cur_side);
				check_field("cur_track", want.cur_track, result.cur_track);
				check_field("cur_sector", want.cur_sector, result.cur_sector);
				check_field("is_filler", 8'(want.is_filler), 8'(result.is_filler));
				fetches_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic issue(input req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_request(r);
		if (r.func != FUNC_UNUSED) requests_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_pulses.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// end markers past the longest track keep every walk inside written bytes
	task automatic write_guard();
		for (int g = 0; g < GUARD_LEN; g++)
			issue(make_req(FUNC_WRITE, ADDR_W'(GUARD_AT + g), end_code));
	endtask

	task automatic set_markers(input logic [7:0] end_val, input logic [7:0] sec_val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_END_MARKER;
		cfg_data <= end_val;
		@(posedge clk);
		cfg_index <= CFG_SECTOR_MARKER;
		cfg_data <= sec_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		end_code = end_val;
		sector_code = sec_val;
		settings_used++;
		write_guard();
	endtask

	task automatic fetch_one();
		issue(make_req(FUNC_FETCH, ADDR_W'($urandom), 8'($urandom)));
	endtask

	task automatic put_byte(inout logic [ADDR_W-1:0] wa, input logic [7:0] d);
		issue(make_req(FUNC_WRITE, wa, d));
		wa = wa + 1'b1;
	endtask

	task automatic maybe_noise();
		if ($urandom_range(99) < 6) begin
			case ($urandom_range(2))
				0: issue(make_req(FUNC_WRITE, ADDR_W'($urandom_range(GUARD_AT - 1)),
					8'($urandom)));
				1: issue(make_req(FUNC_UNUSED, ADDR_W'($urandom), 8'($urandom)));
				default: issue(make_req(FUNC_REWIND, ADDR_W'($urandom), 8'($urandom)));
			endcase
		end
	endtask

	task automatic load_lead_in();
		for (int a = START_OFFSET; a < GUARD_AT; a++)
			issue(make_req(FUNC_WRITE, ADDR_W'(a), 8'h00));
		write_guard();
	endtask

	task automatic test_sector_capture();
		issue(make_req(FUNC_WRITE, PTR_START, SECTOR_RESET));
		issue(make_req(FUNC_WRITE, PTR_START + ADDR_W'(1), 8'h11));
		issue(make_req(FUNC_WRITE, PTR_START + ADDR_W'(2), 8'h22));
		issue(make_req(FUNC_WRITE, PTR_START + ADDR_W'(3), 8'h33));
		issue(make_req(FUNC_WRITE, PTR_START + ADDR_W'(4), 8'he4));
		issue(make_req(FUNC_FETCH, '1, '1));
	endtask

	task automatic test_end_marker();
		issue(make_req(FUNC_WRITE, PTR_START + ADDR_W'(3), END_RESET));
		issue(make_req(FUNC_FETCH, '0, '0));
		issue(make_req(FUNC_FETCH, '0, '0));
	endtask

	task automatic test_odd_requests();
		issue(make_req(FUNC_WRITE, '0, 8'hff));
		issue(make_req(FUNC_WRITE, PTR_LAST, 8'h00));
		issue(make_req(FUNC_UNUSED, '1, '1));
		issue(make_req(FUNC_REWIND, '1, '1));
		issue(make_req(FUNC_FETCH, '0, '0));
	endtask

	task automatic test_marker_settings();
		// zero end marker wins over the zero skip
		set_markers(8'h00, 8'h00);
		issue(make_req(FUNC_REWIND, '0, '0));
		issue(make_req(FUNC_WRITE, PTR_START, 8'h00));
		issue(make_req(FUNC_FETCH, '0, '0));
		// end marker wins over an equal sector marker
		set_markers(8'h33, 8'h33);
		issue(make_req(FUNC_WRITE, PTR_START, 8'h33));
		issue(make_req(FUNC_REWIND, '0, '0));
		issue(make_req(FUNC_FETCH, '0, '0));
		// zero sector marker never captures
		set_markers(8'hff, 8'h00);
		issue(make_req(FUNC_WRITE, PTR_START, 8'h00));
		issue(make_req(FUNC_WRITE, PTR_START + ADDR_W'(1), 8'h00));
		issue(make_req(FUNC_REWIND, '0, '0));
		issue(make_req(FUNC_FETCH, '0, '0));
	endtask

	task automatic play_track();
		logic [ADDR_W-1:0] wa;
		int                ntok, ndata, nfetch, kind;
		logic              broken;
		broken = ($urandom_range(14) == 0);
		wa = PTR_START;
		ndata = 0;
		ntok = $urandom_range(24, 2);
		for (int k = 0; k < ntok; k++) begin
			kind = $urandom_range(99);
			if (kind < 15) begin
				put_byte(wa, 8'h00);
			end else if (kind < 30) begin
				put_byte(wa, sector_code);
				repeat (3) put_byte(wa, 8'($urandom));
			end else begin
				put_byte(wa, 8'($urandom));
				ndata++;
			end
			maybe_noise();
		end
		if (!broken) put_byte(wa, end_code);
		if ($urandom_range(3) == 0) wait_drained();
		issue(make_req(FUNC_REWIND, ADDR_W'($urandom), 8'($urandom)));
		nfetch = ndata + $urandom_range(2);
		for (int k = 0; k < nfetch; k++) begin
			maybe_noise();
			fetch_one();
		end
	endtask

	task automatic test_random_tracks(input int pct, input logic [7:0] end_val,
			input logic [7:0] sec_val);
		int goal;
		set_markers(end_val, sec_val);
		idle_pct = pct;
		goal = requests_sent + BLOCK_ITEMS;
		while (requests_sent < goal) play_track();
		idle_pct = 0;
	endtask

	initial begin
		walk_ptr = PTR_START;
		side_seen = MARK_UNKNOWN;
		track_seen = MARK_UNKNOWN;
		sector_seen = MARK_UNKNOWN;
		end_code = END_RESET;
		sector_code = SECTOR_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_lead_in();
		test_sector_capture();
		test_end_marker();
		test_odd_requests();
		test_marker_settings();
		test_random_tracks(38, END_RESET, SECTOR_RESET);
		test_random_tracks(38, 8'h00, 8'hff);
		test_random_tracks(63, 8'hc3, 8'h00);
		test_random_tracks(63, 8'h5a, 8'h5a);
		test_random_tracks(0, 8'($urandom), 8'($urandom));
		test_random_tracks(0, 8'hff, 8'hfe);
		wait_drained();
		repeat (8) @(posedge clk);
		$display("run: %0d requests, %0d fetch results checked (%0d filler)",
			requests_sent, fetches_checked, fillers_predicted);
		$display("run: %0d marker settings, %0d mismatches", settings_used, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
src/tsp_pkg.sv
src/tsp_ctrl.sv
src/tsp_dp.sv
src/track_stream_to_pulse_widths.sv
tb/tb_track_stream_to_pulse_widths.sv
